[hw/rtl/ldpr_pkg.sv]
// Package of the line, disc and point rasterizer: sizes, codes, types and
// the disc stamp rows. Every other file of the block but ldpr_channels depends on it.
package ldpr_pkg;

   localparam int STORE_PIXELS  = 524288;
   localparam int STORE_AW      = $clog2(STORE_PIXELS);
   localparam int SCREEN_WIDTH  = 640;
   localparam int SCREEN_HEIGHT = 350;
   localparam int ROW_GROUPS    = 80;
   localparam int COORD_W       = 18;
   localparam int MULT_W        =
      $clog2((SCREEN_WIDTH > ROW_GROUPS ? SCREEN_WIDTH : ROW_GROUPS) + 1);
   localparam int COUNT_W       = 17;
   localparam int ERR_W         = 20;
   localparam logic [15:0] PAGE0_BASE = 16'h7e00;

   localparam logic [1:0] OP_LINE  = 2'd0;
   localparam logic [1:0] OP_DISC  = 2'd1;
   localparam logic [1:0] OP_POINT = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   localparam logic CSR_ADDRESS_MODE = 1'b0;
   localparam logic CSR_PAGE_SELECT  = 1'b1;

   localparam logic [2:0] DISC_SIZE_FOUR = 3'd5;

   typedef struct packed {
      logic address_mode;
      logic page_select;
   } cfg_type;

   typedef struct packed {
      logic                valid;
      logic [STORE_AW-1:0] index;
   } pixel_addr_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LINE_SWAP,
      ST_LINE_DELTA,
      ST_LINE_SETUP,
      ST_LINE_STEP,
      ST_DISC_CHECK,
      ST_DISC_BIT,
      ST_DISC_NEXT,
      ST_PX_MUL,
      ST_PX_SUM,
      ST_PX_RD,
      ST_PX_WR,
      ST_DONE
   } state_type;

   function automatic logic [10:0] stamp_row(input logic four, input logic [2:0] row);
      logic [10:0] bits;
      bits = 11'h000;
      if (four) begin
         case (row)
            3'd0: bits = 11'h1c0;
            3'd1: bits = 11'h3e0;
            3'd2: bits = 11'h3e0;
            3'd3: bits = 11'h1c0;
            default: bits = 11'h000;
         endcase
      end else begin
         case (row)
            3'd0: bits = 11'h3c0;
            3'd1: bits = 11'h7e0;
            3'd2: bits = 11'h7e0;
            3'd3: bits = 11'h7e0;
            3'd4: bits = 11'h3c0;
            default: bits = 11'h000;
         endcase
      end
      return bits;
   endfunction

endpackage

[hw/rtl/ldpr_channels.sv]
// Handshake channels of the rasterizer: the command item and the result item.
// Depends on nothing.
interface ldpr_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic signed [15:0] x_start;
   logic signed [15:0] y_start;
   logic signed [15:0] x_end;
   logic signed [15:0] y_end;
   logic [3:0]         draw_color;
   logic [3:0]         plane_mask;
   logic [2:0]         disc_size;
   logic signed [15:0] window_left;
   logic signed [15:0] window_top;
   logic signed [15:0] window_right;
   logic signed [15:0] window_bottom;

   modport source (output valid, operation, x_start, y_start, x_end, y_end, draw_color,
                   plane_mask, disc_size, window_left, window_top, window_right,
                   window_bottom, input ready);
   modport sink (input valid, operation, x_start, y_start, x_end, y_end, draw_color,
                 plane_mask, disc_size, window_left, window_top, window_right,
                 window_bottom, output ready);
endinterface

interface ldpr_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  read_value;
   logic [16:0] pixels_written;

   modport source (output valid, read_value, pixels_written, input ready);
   modport sink (input valid, read_value, pixels_written, output ready);
endinterface

[hw/rtl/ldpr_pixel_ram.sv]
// Pixel store of 4-bit entries with one write port and one registered read port.
// Depends on ldpr_pkg.
module ldpr_pixel_ram (
   input  logic                         clock,
   input  logic [ldpr_pkg::STORE_AW-1:0] rd_addr,
   output logic [3:0]                   rd_data_ff,
   input  logic                         wr_en,
   input  logic [ldpr_pkg::STORE_AW-1:0] wr_addr,
   input  logic [3:0]                   wr_data
);

   logic [3:0] mem [ldpr_pkg::STORE_PIXELS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

[hw/rtl/ldpr_addr_unit.sv]
// Shared two-stage address unit: clips or wraps one pixel coordinate and
// forms its store index. Depends on ldpr_pkg.
module ldpr_addr_unit (
   input  logic                                 clock,
   input  logic signed [ldpr_pkg::COORD_W-1:0]  x,
   input  logic signed [ldpr_pkg::COORD_W-1:0]  y,
   input  ldpr_pkg::cfg_type                    cfg,
   output ldpr_pkg::pixel_addr_type             addr_ff
);

   localparam int PROD_W = ldpr_pkg::COORD_W + ldpr_pkg::MULT_W + 1;
   localparam int WIDE_W = ldpr_pkg::STORE_AW + 1;
   localparam logic signed [ldpr_pkg::COORD_W-1:0] SCR_W =
      ldpr_pkg::COORD_W'(ldpr_pkg::SCREEN_WIDTH);
   localparam logic signed [ldpr_pkg::COORD_W-1:0] SCR_H =
      ldpr_pkg::COORD_W'(ldpr_pkg::SCREEN_HEIGHT);

   logic [ldpr_pkg::MULT_W-1:0]          mult;
   logic signed [PROD_W-1:0]             prod_in, prod_ff;
   logic signed [ldpr_pkg::COORD_W-1:0]  x_ff;
   logic                                 onscreen_in, onscreen_ff;
   logic                                 paged_ff, page_ff;
   logic [15:0]                          group;
   logic [WIDE_W-1:0]                    wide;
   logic [WIDE_W-1:0]                    reduced;
   ldpr_pkg::pixel_addr_type             addr_in;

   always_comb begin
      mult = cfg.address_mode ? ldpr_pkg::MULT_W'(ldpr_pkg::ROW_GROUPS)
                              : ldpr_pkg::MULT_W'(ldpr_pkg::SCREEN_WIDTH);
      prod_in = y * $signed({1'b0, mult});
      onscreen_in = (x >= 0) && (x < SCR_W) && (y >= 0) && (y < SCR_H);
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      x_ff        <= x;
      onscreen_ff <= onscreen_in;
      paged_ff    <= cfg.address_mode;
      page_ff     <= cfg.page_select;
   end

   always_comb begin
      group = prod_ff[15:0] + {x_ff[ldpr_pkg::COORD_W-1], x_ff[17:3]}
              + (page_ff ? 16'h0000 : ldpr_pkg::PAGE0_BASE);
      if (paged_ff) begin
         wide = WIDE_W'({group, x_ff[2:0]});
      end else begin
         wide = WIDE_W'(prod_ff) + WIDE_W'(x_ff);
      end
      reduced = (wide >= WIDE_W'(ldpr_pkg::STORE_PIXELS))
                ? wide - WIDE_W'(ldpr_pkg::STORE_PIXELS) : wide;
      addr_in.valid = paged_ff || onscreen_ff;
      addr_in.index = reduced[ldpr_pkg::STORE_AW-1:0];
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
   end

endmodule

[hw/rtl/line_disc_point_rasterizer_core.sv]
// Top level of the line, disc and point rasterizer: command sequencer, result
// register and clearing pass. Depends on ldpr_pkg, ldpr_channels,
// ldpr_addr_unit and ldpr_pixel_ram.
//
//   port       direction  role
//   req_chan   sink       command items: operation, coordinates, colour, window
//   rsp_chan   source     result items: read value and pixel count
//   csr_*      input      register writes: address mode, page select
//
// Each pixel passes through the two-stage address unit and the single
// read-modify-write port of the store, in the states multiply, sum, read and
// write. A disc whose centre lies outside its window draws nothing.
// After reset a clearing pass writes zero to all 524288 entries, one a cycle,
// and no item is accepted until it ends; register writes are taken meanwhile.
// A finished result waits in the output register; the next item is accepted
// while it waits, and its own result holds the sequencer until the register frees.
module line_disc_point_rasterizer_core (
   input  logic      clock,
   input  logic      reset,
   ldpr_req_if.sink   req_chan,
   ldpr_rsp_if.source rsp_chan,
   input  logic      csr_write_enable,
   input  logic      csr_index,
   input  logic      csr_write_data
);

   localparam int CW = ldpr_pkg::COORD_W;

   ldpr_pkg::state_type      state_ff, state_in, ret_ff;
   ldpr_pkg::cfg_type        cfg_ff;
   ldpr_pkg::pixel_addr_type addr;

   logic [ldpr_pkg::STORE_AW-1:0] clr_ff;
   logic signed [CW-1:0]          px_ff, py_ff, ex_ff, ey_ff, base_ff;
   logic [1:0]                    op_ff;
   logic [3:0]                    color_ff, mask_ff;
   logic                          four_ff;
   logic signed [15:0]            wl_ff, wt_ff, wr_ff, wb_ff;
   logic [ldpr_pkg::COUNT_W-1:0]  dx_ff, dy_ff, major_ff, minor_ff, count_ff, written_ff;
   logic                          sy_neg_ff;
   logic signed [ldpr_pkg::ERR_W-1:0] err_ff;
   logic [2:0]                    row_ff;
   logic [4:0]                    bit_ff;
   logic [3:0]                    readv_ff;
   logic                          rsp_valid_ff;
   logic [3:0]                    rsp_read_ff;
   logic [16:0]                   rsp_written_ff;

   logic                          accept;
   logic                          in_window;
   logic [23:0]                   pattern;
   logic [3:0]                    rd_data;
   logic [ldpr_pkg::STORE_AW-1:0] rd_addr, wr_addr;
   logic                          wr_en;
   logic [3:0]                    wr_data;
   logic                          result_load;
   logic signed [CW-1:0]          x_sx, x2_sx;
   logic signed [ldpr_pkg::ERR_W-1:0] two_minor, two_major;
   logic [2:0]                    last_row;

   ldpr_addr_unit u_addr (
      .clock   (clock),
      .x       (px_ff),
      .y       (py_ff),
      .cfg     (cfg_ff),
      .addr_ff (addr)
   );

   ldpr_pixel_ram u_ram (
      .clock      (clock),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

   always_comb begin
      accept    = req_chan.valid && req_chan.ready;
      in_window = ($signed(px_ff[15:0]) >= wl_ff) && ($signed(px_ff[15:0]) < wr_ff)
                  && ($signed(py_ff[15:0]) >= wt_ff) && ($signed(py_ff[15:0]) < wb_ff);
      pattern   = {5'b0, ldpr_pkg::stamp_row(four_ff, row_ff), 8'b0} >> px_ff[2:0];
      x_sx      = CW'(req_chan.x_start);
      x2_sx     = CW'(req_chan.x_end);
      two_minor = ldpr_pkg::ERR_W'({minor_ff, 1'b0});
      two_major = ldpr_pkg::ERR_W'({major_ff, 1'b0});
      last_row  = four_ff ? 3'd3 : 3'd4;
      result_load = (state_ff == ldpr_pkg::ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ldpr_pkg::ST_CLEAR: begin
            if (clr_ff == ldpr_pkg::STORE_AW'(ldpr_pkg::STORE_PIXELS - 1)) begin
               state_in = ldpr_pkg::ST_IDLE;
            end
         end
         ldpr_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_chan.operation)
                  ldpr_pkg::OP_LINE:  state_in = ldpr_pkg::ST_LINE_SWAP;
                  ldpr_pkg::OP_DISC:  state_in = ldpr_pkg::ST_DISC_CHECK;
                  default:            state_in = ldpr_pkg::ST_PX_MUL;
               endcase
            end
         end
         ldpr_pkg::ST_LINE_SWAP:  state_in = ldpr_pkg::ST_LINE_DELTA;
         ldpr_pkg::ST_LINE_DELTA: state_in = ldpr_pkg::ST_LINE_SETUP;
         ldpr_pkg::ST_LINE_SETUP: state_in = ldpr_pkg::ST_PX_MUL;
         ldpr_pkg::ST_LINE_STEP: begin
            state_in = (count_ff == '0) ? ldpr_pkg::ST_DONE : ldpr_pkg::ST_PX_MUL;
         end
         ldpr_pkg::ST_DISC_CHECK: begin
            state_in = in_window ? ldpr_pkg::ST_DISC_BIT : ldpr_pkg::ST_DONE;
         end
         ldpr_pkg::ST_DISC_BIT: begin
            state_in = pattern[5'd23 - bit_ff] ? ldpr_pkg::ST_PX_MUL : ldpr_pkg::ST_DISC_NEXT;
         end
         ldpr_pkg::ST_DISC_NEXT: begin
            if (bit_ff == 5'd23 && row_ff == last_row) begin
               state_in = ldpr_pkg::ST_DONE;
            end else begin
               state_in = ldpr_pkg::ST_DISC_BIT;
            end
         end
         ldpr_pkg::ST_PX_MUL: state_in = ldpr_pkg::ST_PX_SUM;
         ldpr_pkg::ST_PX_SUM: state_in = ldpr_pkg::ST_PX_RD;
         ldpr_pkg::ST_PX_RD:  state_in = ldpr_pkg::ST_PX_WR;
         ldpr_pkg::ST_PX_WR:  state_in = ret_ff;
         ldpr_pkg::ST_DONE: begin
            if (result_load) begin
               state_in = ldpr_pkg::ST_IDLE;
            end
         end
         default: state_in = ldpr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_chan.ready = (state_ff == ldpr_pkg::ST_IDLE);
      rd_addr = addr.index;
      wr_en   = 1'b0;
      wr_addr = addr.index;
      wr_data = (rd_data & ~mask_ff) | (color_ff & mask_ff);
      case (state_ff)
         ldpr_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = 4'h0;
         end
         ldpr_pkg::ST_PX_WR: begin
            wr_en = addr.valid && (op_ff != ldpr_pkg::OP_READ);
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ldpr_pkg::ST_CLEAR;
         clr_ff       <= '0;
         cfg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ldpr_pkg::ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (csr_write_enable) begin
            case (csr_index)
               ldpr_pkg::CSR_ADDRESS_MODE: cfg_ff.address_mode <= csr_write_data;
               ldpr_pkg::CSR_PAGE_SELECT:  cfg_ff.page_select  <= csr_write_data;
               default: cfg_ff <= cfg_ff;
            endcase
         end
         if (result_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ldpr_pkg::ST_IDLE: begin
            op_ff      <= req_chan.operation;
            px_ff      <= x_sx;
            py_ff      <= CW'(req_chan.y_start);
            ex_ff      <= x2_sx;
            ey_ff      <= CW'(req_chan.y_end);
            color_ff   <= req_chan.draw_color;
            mask_ff    <= req_chan.plane_mask;
            four_ff    <= (req_chan.disc_size == ldpr_pkg::DISC_SIZE_FOUR);
            wl_ff      <= req_chan.window_left;
            wt_ff      <= req_chan.window_top;
            wr_ff      <= req_chan.window_right;
            wb_ff      <= req_chan.window_bottom;
            written_ff <= '0;
            readv_ff   <= 4'h0;
            ret_ff     <= ldpr_pkg::ST_DONE;
         end
         ldpr_pkg::ST_LINE_SWAP: begin
            if (ex_ff < px_ff) begin
               px_ff <= ex_ff;
               py_ff <= ey_ff;
               ex_ff <= px_ff;
               ey_ff <= py_ff;
            end
         end
         ldpr_pkg::ST_LINE_DELTA: begin
            dx_ff     <= ldpr_pkg::COUNT_W'(ex_ff - px_ff);
            dy_ff     <= (ey_ff >= py_ff) ? ldpr_pkg::COUNT_W'(ey_ff - py_ff)
                                          : ldpr_pkg::COUNT_W'(py_ff - ey_ff);
            sy_neg_ff <= (ey_ff < py_ff);
         end
         ldpr_pkg::ST_LINE_SETUP: begin
            major_ff <= (dx_ff >= dy_ff) ? dx_ff : dy_ff;
            minor_ff <= (dx_ff >= dy_ff) ? dy_ff : dx_ff;
            count_ff <= (dx_ff >= dy_ff) ? dx_ff : dy_ff;
            err_ff   <= ldpr_pkg::ERR_W'({(dx_ff >= dy_ff) ? dy_ff : dx_ff, 1'b0})
                        - ldpr_pkg::ERR_W'((dx_ff >= dy_ff) ? dx_ff : dy_ff);
            ret_ff   <= ldpr_pkg::ST_LINE_STEP;
         end
         ldpr_pkg::ST_LINE_STEP: begin
            if (dy_ff <= dx_ff) begin
               px_ff <= px_ff + 1'b1;
               if (!err_ff[ldpr_pkg::ERR_W-1]) begin
                  py_ff <= sy_neg_ff ? py_ff - 1'b1 : py_ff + 1'b1;
               end
            end else begin
               py_ff <= sy_neg_ff ? py_ff - 1'b1 : py_ff + 1'b1;
               if (!err_ff[ldpr_pkg::ERR_W-1]) begin
                  px_ff <= px_ff + 1'b1;
               end
            end
            err_ff   <= err_ff + two_minor - (err_ff[ldpr_pkg::ERR_W-1] ? '0 : two_major);
            count_ff <= count_ff - 1'b1;
         end
         ldpr_pkg::ST_DISC_CHECK: begin
            base_ff <= {px_ff[CW-1:3], 3'b000} - CW'(8);
            ex_ff   <= px_ff;
            ey_ff   <= py_ff;
            row_ff  <= 3'd0;
            bit_ff  <= 5'd0;
            ret_ff  <= ldpr_pkg::ST_DISC_NEXT;
         end
         ldpr_pkg::ST_DISC_BIT: begin
            px_ff <= base_ff + CW'(bit_ff);
            py_ff <= ey_ff + CW'(row_ff) - CW'(2);
         end
         ldpr_pkg::ST_DISC_NEXT: begin
            px_ff <= ex_ff;
            if (bit_ff == 5'd23) begin
               bit_ff <= 5'd0;
               row_ff <= row_ff + 1'b1;
            end else begin
               bit_ff <= bit_ff + 1'b1;
            end
         end
         ldpr_pkg::ST_PX_WR: begin
            if (addr.valid) begin
               if (op_ff == ldpr_pkg::OP_READ) begin
                  readv_ff <= rd_data;
               end else begin
                  written_ff <= written_ff + 1'b1;
               end
            end
         end
         default: begin
            op_ff <= op_ff;
         end
      endcase
      if (result_load) begin
         rsp_read_ff    <= readv_ff;
         rsp_written_ff <= written_ff;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.read_value     = rsp_read_ff;
   assign rsp_chan.pixels_written = rsp_written_ff;

`ifndef SYNTH
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ldpr_pkg::ST_CLEAR) |-> !req_chan.ready)
      else $error("item accepted during clearing pass");
   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ldpr_pkg::ST_CLEAR || state_ff == ldpr_pkg::ST_PX_WR))
      else $error("store written outside a write phase");
   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ldpr_pkg::ST_PX_WR && op_ff == ldpr_pkg::OP_READ)
      |=> $stable(written_ff))
      else $error("read item changed the pixel count");
`endif

endmodule
